// ===== design/stepper_move_step_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Stepper move step generator assertion macros
// Shared property wrappers for the concurrent checks in the design files.
// ----------------------------------------------------------------------------
`ifndef STEPPER_MOVE_STEP_GENERATOR_MACROS_SVH
`define STEPPER_MOVE_STEP_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SMSG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SMSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/smsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper move step generator package
// Widths, operation and direction codes, and the divider request type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smsg_pkg;

  localparam int POS_BITS  = 32;
  localparam int FRAC_BITS = 8;

  localparam int OP_W   = 2;
  localparam int GOAL_W = 32;
  localparam int MT_W   = 24;
  localparam int SPD_W  = 20;
  localparam int MIN_W  = 16;
  localparam int IV_W   = 48;

  localparam int US_PER_MS = 1000;
  localparam int US_PER_S  = 1000000;
  localparam int MS_W      = 10;

  // Dividend: move time in microseconds, scaled by the fraction bits
  localparam int PROD_W    = MT_W + MS_W;
  localparam int NUM_W     = PROD_W + FRAC_BITS;
  localparam int DVS_W     = (POS_BITS > SPD_W) ? POS_BITS : SPD_W;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam logic [IV_W-1:0]  IV_MAX       = '1;
  localparam logic [NUM_W-1:0] SPD_DIVIDEND = NUM_W'(US_PER_S) << FRAC_BITS;
  localparam logic [IV_W-1:0]  IV_ONE       = IV_W'(1) << FRAC_BITS;

  localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE_TIME  = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE_SPEED = 2'd2;
  localparam logic [OP_W-1:0] OP_STATUS     = 2'd3;

  typedef logic [1:0] dir_t;
  localparam dir_t DIR_NONE = 2'd0;
  localparam dir_t DIR_CW   = 2'd1;
  localparam dir_t DIR_CCW  = 2'd2;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== design/smsg_div.sv =====
// ----------------------------------------------------------------------------
// Stepper move step generator divider
// Restoring divider, one quotient bit per cycle, shared by both move ops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stepper_move_step_generator_macros.svh"

module smsg_div (
  input  logic                      clk,
  input  logic                      rst,
  input  smsg_pkg::div_req_t        req,
  output logic                      done,
  output logic [smsg_pkg::NUM_W-1:0] quotient
);
  import smsg_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]     rem;
  logic [NUM_W-1:0]     dvd;
  logic [DVS_W-1:0]     divisor_r;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       trial_diff;
  logic                 fits;
  logic                 busy;

  assign busy       = (cnt != '0);
  assign trial      = {rem, dvd[NUM_W-1]};
  assign fits       = (trial >= {1'b0, divisor_r});
  assign trial_diff = trial - {1'b0, divisor_r};
  assign quotient   = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      // flag the cycle after the last quotient bit
      done <= !req.start && (cnt == DIV_CNT_W'(1));
      if (req.start) begin
        cnt       <= DIV_CNT_W'(NUM_W);
        rem       <= '0;
        dvd       <= req.dividend;
        divisor_r <= req.divisor;
      end else if (busy) begin
        // shift the next dividend bit in, keep the quotient bit in its place
        rem <= fits ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
        dvd <= {dvd[NUM_W-2:0], fits};
        cnt <= cnt - DIV_CNT_W'(1);
      end
    end
  end

  `SMSG_ASSERT_IMPL(a_start_idle, clk, rst, req.start, !busy, "divider started while busy")
  `SMSG_ASSERT_IMPL(a_divisor_nz, clk, rst, req.start, req.divisor != '0, "zero divisor")
  `SMSG_ASSERT_IMPL(a_done_last, clk, rst, done, !busy, "done while iterating")

endmodule

// ===== design/stepper_move_step_generator.sv =====
// ----------------------------------------------------------------------------
// Stepper move step generator
// Constant-rate step/direction generator with timed and speed moves.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A tick that finds a move running passes
// through S_DECODE, S_TICK2, S_TICK3 and S_OUT; an idle tick or a status item
// passes through S_DECODE and S_OUT. A move that needs an interval waits on
// the serial restoring divider, which works out its 42 quotient bits one after
// another; a move with a move time first passes S_MUL. A move whose goal equals
// the current position, or one with zero speed, skips the divider. A result
// waits in S_OUT while the previous one is held by out_stall. The next item is
// taken as soon as the result sits in the output register.
`timescale 1ns / 1ps
`include "stepper_move_step_generator_macros.svh"

module stepper_move_step_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [smsg_pkg::MIN_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [smsg_pkg::OP_W-1:0]         op,
  input  logic signed [smsg_pkg::GOAL_W-1:0] goal_position,
  input  logic [smsg_pkg::MT_W-1:0]         move_time_ms,
  input  logic [smsg_pkg::SPD_W-1:0]        speed_sps,
  input  logic                              clear_finished,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              step_pulse,
  output logic                              dir_cw,
  output logic                              running,
  output logic                              finished,
  output logic signed [smsg_pkg::GOAL_W-1:0] position_now,
  output logic signed [smsg_pkg::GOAL_W-1:0] position_goal
);
  import smsg_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_DIVGO  = 4'd3;
  localparam logic [3:0] S_DIVW   = 4'd4;
  localparam logic [3:0] S_START  = 4'd5;
  localparam logic [3:0] S_TICK2  = 4'd6;
  localparam logic [3:0] S_TICK3  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]                 state;
  logic [OP_W-1:0]            op_r;
  logic [MT_W-1:0]            move_time_r;
  logic [SPD_W-1:0]           speed_r;
  logic                       clear_r;
  logic                       step_r;
  logic                       neq_r;
  logic                       neg_r;
  logic [MIN_W-1:0]           min_interval_us;
  logic signed [POS_BITS-1:0] current_pos;
  logic signed [POS_BITS-1:0] target_pos;
  logic [IV_W-1:0]            step_interval;
  logic [IV_W-1:0]            elapsed;
  dir_t                       dir_state;
  logic                       run_flag;
  logic                       done_flag;
  logic [NUM_W-1:0]           dividend_r;
  logic [DVS_W-1:0]           divisor_r;

  logic signed [POS_BITS:0]   diff;
  logic [POS_BITS:0]          diff_abs;
  logic [PROD_W-1:0]          prod;
  logic [IV_W:0]              elapsed_inc;
  logic [IV_W-1:0]            min_lo;
  logic                       out_load;
  div_req_t                   div_req;
  logic                       div_done;
  logic [NUM_W-1:0]           div_quot;

  assign diff     = (POS_BITS+1)'(target_pos) - (POS_BITS+1)'(current_pos);
  assign diff_abs = diff[POS_BITS] ? (POS_BITS+1)'(-diff) : (POS_BITS+1)'(diff);
  assign prod     = PROD_W'(move_time_r) * PROD_W'(US_PER_MS);
  assign elapsed_inc = {1'b0, elapsed} + {1'b0, IV_ONE};
  assign min_lo   = IV_W'(min_interval_us) << FRAC_BITS;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  assign div_req.start    = (state == S_DIVGO);
  assign div_req.dividend = dividend_r;
  assign div_req.divisor  = divisor_r;

  assign in_stall = (state != S_IDLE);

  smsg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      current_pos     <= '0;
      target_pos      <= '0;
      step_interval   <= '0;
      elapsed         <= '0;
      dir_state       <= DIR_NONE;
      run_flag        <= 1'b0;
      done_flag       <= 1'b0;
      min_interval_us <= MIN_W'(1);
      step_r          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_interval_us <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r        <= op;
            move_time_r <= move_time_ms;
            speed_r     <= speed_sps;
            clear_r     <= clear_finished;
            step_r      <= 1'b0;
            if (op == OP_MOVE_TIME || op == OP_MOVE_SPEED) begin
              target_pos <= goal_position[POS_BITS-1:0];
            end
            state <= S_DECODE;
          end
        end

        S_DECODE: begin
          neq_r     <= (diff != '0);
          neg_r     <= diff[POS_BITS];
          case (op_r)
            OP_TICK: begin
              if (run_flag) begin
                // saturate at the top of the counter
                elapsed <= elapsed_inc[IV_W] ? IV_MAX : elapsed_inc[IV_W-1:0];
                state   <= S_TICK2;
              end else begin
                state <= S_OUT;
              end
            end
            OP_MOVE_TIME: begin
              divisor_r <= DVS_W'(diff_abs[POS_BITS-1:0]);
              state     <= (diff != '0) ? S_MUL : S_START;
            end
            OP_MOVE_SPEED: begin
              if (diff == '0) begin
                state <= S_START;
              end else if (speed_r == '0) begin
                step_interval <= IV_MAX;
                state         <= S_START;
              end else begin
                dividend_r <= SPD_DIVIDEND;
                divisor_r  <= DVS_W'(speed_r);
                state      <= S_DIVGO;
              end
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end

        S_MUL: begin
          dividend_r <= NUM_W'(prod) << FRAC_BITS;
          state      <= S_DIVGO;
        end

        S_DIVGO: begin
          state <= S_DIVW;
        end

        S_DIVW: begin
          if (div_done) begin
            step_interval <= IV_W'(div_quot);
            state         <= S_START;
          end
        end

        S_START: begin
          if (neq_r) begin
            if (step_interval < min_lo) begin
              step_interval <= min_lo;
            end
            dir_state <= neg_r ? DIR_CCW : DIR_CW;
            run_flag  <= 1'b1;
            elapsed   <= '0;
          end else begin
            dir_state     <= DIR_NONE;
            step_interval <= '0;
            if (run_flag) begin
              run_flag  <= 1'b0;
              done_flag <= 1'b1;
            end
          end
          state <= S_OUT;
        end

        S_TICK2: begin
          if (elapsed >= step_interval) begin
            case (dir_state)
              DIR_CW:  current_pos <= current_pos + POS_BITS'(1);
              DIR_CCW: current_pos <= current_pos - POS_BITS'(1);
              default: current_pos <= current_pos;
            endcase
            step_r  <= 1'b1;
            elapsed <= elapsed - step_interval;
          end
          state <= S_TICK3;
        end

        S_TICK3: begin
          // still late after a step: drop the backlog
          if (step_r && elapsed >= step_interval) begin
            elapsed <= '0;
          end
          if (current_pos == target_pos) begin
            run_flag  <= 1'b0;
            done_flag <= 1'b1;
          end
          state <= S_OUT;
        end

        S_OUT: begin
          if (out_load) begin
            step_pulse    <= step_r;
            dir_cw        <= (dir_state == DIR_CW);
            running       <= run_flag;
            finished      <= done_flag;
            position_now  <= GOAL_W'(current_pos);
            position_goal <= GOAL_W'(target_pos);
            if (op_r == OP_STATUS && clear_r) begin
              done_flag <= 1'b0;
            end
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SMSG_ASSERT_IMPL(a_run_off_goal, clk, rst, state == S_IDLE && run_flag, current_pos != target_pos && dir_state != DIR_NONE, "running at goal or without direction")
  `SMSG_ASSERT_IMPL(a_step_on_tick, clk, rst, state == S_OUT && step_r, op_r == OP_TICK, "step outside a tick")
  `SMSG_ASSERT_IMPL(a_div_done_wait, clk, rst, div_done, state == S_DIVW, "divider result unexpected")

endmodule
